### rtl/vac_pkg.sv
// Shared constants and types for the voice allocator with cooldown.
package vac_pkg;

  localparam int NUM_EFFECTS       = 16;
  localparam int VOICES_PER_EFFECT = 8;

  localparam int FX_W    = 4;
  localparam int COUNT_W = 4;
  localparam int CD_W    = 16;
  localparam int BUSY_W  = 8;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 8;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int NUM_IDX_W  = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
  localparam int CELL_IDX_W = (NUM_IDX_W > FX_W) ? NUM_IDX_W : FX_W;
  localparam int SLOT_W     = (VOICES_PER_EFFECT > 1) ? $clog2(VOICES_PER_EFFECT) : 1;
  localparam int CNT_W      = $clog2(VOICES_PER_EFFECT + 1);
  localparam int SCAN_BUSY_W = (VOICES_PER_EFFECT > BUSY_W) ? VOICES_PER_EFFECT : BUSY_W;
  localparam int MEM_DEPTH  = NUM_EFFECTS * VOICES_PER_EFFECT;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic REQ_PLAY = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic                tick;
    logic                load;
    logic [FX_W-1:0]     fx;
    logic [CD_W-1:0]     reload;
  } cd_ctrl_t;

endpackage

### rtl/voice_allocator_with_cooldown_core.sv
// Top level of the voice allocator: cooldown cell row and request sequencer.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_axis  | in  | fx_index, voice_count, cooldown_reload,         | req_type
//          |     | busy_mask, now_time                             |
//  m_axis  | out | granted, voice_num, stole                       | -
//
//  A tick goes from the transfer straight to the result stage; a play refused or given an
//  idle voice passes the check stage, and the write stage when granted, first.
//  A steal scans the start-time memory one slot a cycle over voice_count slots,
//  with voice_count capped at 8.
//  The single read port of the start-time memory sets the scan length.
//  Reset clears all cooldowns and marks every start time as zero at once.
//  One request is in flight at a time; a stalled result holds the block before idle.
module voice_allocator_with_cooldown_core import vac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fx_index[3:0], voice_count[7:4], cooldown_reload[23:8], busy_mask[31:24],
  // now_time[63:32]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // granted[0], voice_num[8:1], stole[9], zero fill[15:10]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cd_ctrl_t             cd_ctrl;
  logic [NUM_EFFECTS:0] blocked_chain;

  assign blocked_chain[0] = 1'b0;

  for (genvar i = 0; i < NUM_EFFECTS; i++) begin : g_cell
    vac_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (CELL_IDX_W'(i)),
      .ctrl_i    (cd_ctrl),
      .blocked_i (blocked_chain[i]),
      .blocked_o (blocked_chain[i+1])
    );
  end

  vac_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cd_ctrl_o     (cd_ctrl),
    .blocked_i     (blocked_chain[NUM_EFFECTS])
  );

endmodule

### rtl/vac_cell.sv
// One cooldown cell of the effect row: counter, tick decrement and blocked chain.
module vac_cell import vac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CELL_IDX_W-1:0] idx_i,
  input  cd_ctrl_t              ctrl_i,
  input  logic                  blocked_i,
  output logic                  blocked_o
);

  logic [CD_W-1:0] cd_q, cd_d;
  logic            hit;

  assign hit = (CELL_IDX_W'(ctrl_i.fx) == idx_i);

  always_comb begin
    cd_d = cd_q;
    if (ctrl_i.load && hit) begin
      cd_d = ctrl_i.reload;
    end else if (ctrl_i.tick && (cd_q != '0)) begin
      cd_d = cd_q - CD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q <= '0;
    end else begin
      cd_q <= cd_d;
    end
  end

  assign blocked_o = blocked_i | (hit & (cd_q != '0));

endmodule

### rtl/vac_ctrl.sv
// Request sequencer: slot choice, oldest-voice scan over start-time memory, result register.
module vac_ctrl import vac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output cd_ctrl_t               cd_ctrl_o,
  input  logic                   blocked_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [FX_W-1:0]     fx_q, fx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CD_W-1:0]     reload_q, reload_d;
  logic [BUSY_W-1:0]   busy_q, busy_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic                granted_q, granted_d;
  logic                stole_q, stole_d;
  logic [SLOT_W-1:0]   pick_q, pick_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                pend_q;
  logic [SLOT_W-1:0]   pidx_q;
  logic [TIME_W-1:0]   oldest_q, oldest_d;

  logic                out_valid_q, out_valid_d;
  logic                out_granted_q, out_granted_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic                out_stole_q, out_stole_d;

  logic [TIME_W-1:0]   mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [TIME_W-1:0]   rdata_q;
  logic                rd_ok_q;
  logic [TIME_W-1:0]   rd_time;

  logic                in_xfer;
  logic                scan_issue;
  logic                mem_we;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   waddr;
  logic                fx_ok;
  logic [CNT_W-1:0]    cnt_sat;
  logic [SCAN_BUSY_W-1:0] busy_ext;
  logic                idle_found;
  logic [SLOT_W-1:0]   idle_slot;
  logic                out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign scan_issue    = (state_q == ST_SCAN) && (idx_q < cnt_q);
  assign mem_we        = (state_q == ST_WRITE);
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  assign raddr   = ADDR_W'(32'(fx_q) * VOICES_PER_EFFECT + 32'(idx_q[SLOT_W-1:0]));
  assign waddr   = ADDR_W'(32'(fx_q) * VOICES_PER_EFFECT + 32'(pick_q));
  assign fx_ok   = (32'(fx_q) < NUM_EFFECTS);
  assign rd_time = rd_ok_q ? rdata_q : '0;
  assign busy_ext = SCAN_BUSY_W'(busy_q);

  always_comb begin
    if (32'(s_axis_tdata[7:4]) > VOICES_PER_EFFECT) begin
      cnt_sat = CNT_W'(VOICES_PER_EFFECT);
    end else begin
      cnt_sat = CNT_W'(s_axis_tdata[7:4]);
    end
  end

  always_comb begin
    idle_found = 1'b0;
    idle_slot  = '0;
    for (int i = VOICES_PER_EFFECT - 1; i >= 0; i--) begin
      if ((32'(cnt_q) > i) && !busy_ext[i]) begin
        idle_found = 1'b1;
        idle_slot  = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    fx_d      = fx_q;
    cnt_d     = cnt_q;
    reload_d  = reload_q;
    busy_d    = busy_q;
    now_d     = now_q;
    granted_d = granted_q;
    stole_d   = stole_q;
    pick_d    = pick_q;
    idx_d     = idx_q;
    oldest_d  = oldest_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          fx_d      = s_axis_tdata[3:0];
          cnt_d     = cnt_sat;
          reload_d  = s_axis_tdata[23:8];
          busy_d    = s_axis_tdata[31:24];
          now_d     = s_axis_tdata[63:32];
          granted_d = 1'b0;
          stole_d   = 1'b0;
          pick_d    = '0;
          state_d   = (s_axis_tuser == REQ_TICK) ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!fx_ok || blocked_i || (cnt_q == '0)) begin
          state_d = ST_OUT;
        end else if (idle_found) begin
          granted_d = 1'b1;
          pick_d    = idle_slot;
          state_d   = ST_WRITE;
        end else begin
          granted_d = 1'b1;
          stole_d   = 1'b1;
          idx_d     = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (pend_q && ((pidx_q == '0) || (rd_time < oldest_q))) begin
          oldest_d = rd_time;
          pick_d   = pidx_q;
        end
        if (!scan_issue && !pend_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_granted_d = out_granted_q;
    out_id_d      = out_id_q;
    out_stole_d   = out_stole_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d   = 1'b1;
      out_granted_d = granted_q;
      out_stole_d   = stole_q;
      out_id_d      = granted_q ?
                      ID_W'(32'(fx_q) * VOICES_PER_EFFECT + 32'(pick_q) + 1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      granted_q   <= 1'b0;
      stole_q     <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      granted_q   <= granted_d;
      stole_q     <= stole_d;
      pend_q      <= scan_issue;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q          <= fx_d;
    cnt_q         <= cnt_d;
    reload_q      <= reload_d;
    busy_q        <= busy_d;
    now_q         <= now_d;
    pick_q        <= pick_d;
    oldest_q      <= oldest_d;
    pidx_q        <= idx_q[SLOT_W-1:0];
    out_granted_q <= out_granted_d;
    out_id_q      <= out_id_d;
    out_stole_q   <= out_stole_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= now_q;
    end
    if (scan_issue) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (scan_issue) begin
        rd_ok_q <= vld_q[raddr];
      end
    end
  end

  assign cd_ctrl_o.tick   = in_xfer && (s_axis_tuser == REQ_TICK);
  assign cd_ctrl_o.load   = mem_we;
  assign cd_ctrl_o.fx     = fx_q;
  assign cd_ctrl_o.reload = reload_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_stole_q, out_id_q, out_granted_q});

  a_stole_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stole_q |-> granted_q)
    else $error("steal flagged without a grant");

  a_write_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (state_q == ST_OUT))
    else $error("write-back not followed by result stage");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q != '0) && granted_q && stole_q)
    else $error("scan entered without voices to steal");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("transfer accepted without leaving idle");

endmodule

### tb/sv/vac_grant_checker.sv
// Grant checker for the voice allocator: predicts each result and compares it.
module vac_grant_checker import vac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // fx_index[3:0], voice_count[7:4], cooldown_reload[23:8], busy_mask[31:24],
  // now_time[63:32]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // granted[0], voice_num[8:1], stole[9], zero fill[15:10]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_cnt_o,
  output int                     pending_o,
  output int                     grants_o,
  output int                     steals_o
);

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] voice_num;
    logic            stole;
  } grant_t;

  logic [CD_W-1:0]   cooldown_q [NUM_EFFECTS];
  logic [TIME_W-1:0] stamp_q [MEM_DEPTH];
  grant_t            expected_grants [$];
  int                fail_cnt;
  int                result_cnt;
  int                grant_cnt;
  int                steal_cnt;

  function automatic grant_t predict_grant(input logic req,
                                           input logic [FX_W-1:0] fx,
                                           input logic [COUNT_W-1:0] cnt,
                                           input logic [CD_W-1:0] reload,
                                           input logic [BUSY_W-1:0] busy,
                                           input logic [TIME_W-1:0] now);
    grant_t            res;
    int                n;
    int                base;
    int                pick;
    logic [TIME_W-1:0] oldest;
    logic              idle_hit;
    res      = '0;
    pick     = 0;
    oldest   = '0;
    idle_hit = 1'b0;
    n        = (cnt > VOICES_PER_EFFECT) ? VOICES_PER_EFFECT : int'(cnt);
    base     = int'(fx) * VOICES_PER_EFFECT;
    if (req == REQ_TICK) begin
      foreach (cooldown_q[i]) begin
        if (cooldown_q[i] != '0) cooldown_q[i] = cooldown_q[i] - CD_W'(1);
      end
    end else if (int'(fx) < NUM_EFFECTS && cooldown_q[fx] == '0 && n != 0) begin
      for (int i = 0; i < n; i++) begin
        if (i >= BUSY_W || !busy[i]) begin
          pick     = i;
          idle_hit = 1'b1;
          break;
        end
        if (i == 0 || stamp_q[base+i] < oldest) begin
          pick   = i;
          oldest = stamp_q[base+i];
        end
      end
      stamp_q[base+pick] = now;
      cooldown_q[fx]     = reload;
      res.granted        = 1'b1;
      res.voice_num      = ID_W'(base + pick + 1);
      res.stole          = !idle_hit;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got;
    grant_t want;
    if (!rst_ni) begin
      foreach (cooldown_q[i]) cooldown_q[i] = '0;
      foreach (stamp_q[i]) stamp_q[i] = '0;
      expected_grants.delete();
      fail_cnt   = 0;
      result_cnt = 0;
      grant_cnt  = 0;
      steal_cnt  = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      grants_o   <= 0;
      steals_o   <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.granted   = m_axis_tdata[0];
        got.voice_num = m_axis_tdata[8:1];
        got.stole     = m_axis_tdata[9];
        if (expected_grants.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d arrived with none pending: granted=%0b id=%0d stole=%0b",
                     result_cnt, got.granted, got.voice_num, got.stole);
        end else begin
          want = expected_grants.pop_front();
          if (got.granted != want.granted || got.voice_num != want.voice_num ||
              got.stole != want.stole) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"result %0d mismatch: expected granted=%0b id=%0d stole=%0b,",
                        " got granted=%0b id=%0d stole=%0b"},
                       result_cnt, want.granted, want.voice_num, want.stole,
                       got.granted, got.voice_num, got.stole);
          end
        end
        result_cnt++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_grant(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4],
                             s_axis_tdata[23:8], s_axis_tdata[31:24], s_axis_tdata[63:32]);
        if (want.granted) grant_cnt++;
        if (want.stole) steal_cnt++;
        expected_grants.insert(expected_grants.size(), want);
      end
      fail_cnt_o <= fail_cnt;
      pending_o  <= expected_grants.size();
      grants_o   <= grant_cnt;
      steals_o   <= steal_cnt;
    end
  end

endmodule

### tb/sv/tb_voice_allocator_with_cooldown_core.sv
// Testbench top for the voice allocator: clock, reset, stimulus and verdict.
module tb_voice_allocator_with_cooldown_core;
  import vac_pkg::*;

  localparam int RAND_ITEMS  = 1550;
  localparam int CYCLE_LIMIT = 1000000;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tready = 1'b0;
  logic                   s_axis_tready;
  logic                   m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int fail_cnt;
  int pending;
  int grants;
  int steals;
  int cycle_cnt  = 0;
  int plays_sent = 0;
  int ticks_sent = 0;
  bit quiet      = 1'b0;

  always #1 clk_i = ~clk_i;

  voice_allocator_with_cooldown_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vac_grant_checker u_grant_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .grants_o      (grants),
    .steals_o      (steals)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input logic req, input logic [FX_W-1:0] fx,
                          input logic [COUNT_W-1:0] cnt, input logic [CD_W-1:0] reload,
                          input logic [BUSY_W-1:0] busy, input logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {now, busy, reload, cnt, fx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_TICK) ticks_sent++;
    else plays_sent++;
  endtask

  // hold the sender until every pending result has been transferred
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random();
    logic              req;
    logic [FX_W-1:0]   fx;
    logic [COUNT_W-1:0] cnt;
    logic [CD_W-1:0]   reload;
    logic [BUSY_W-1:0] busy;
    logic [TIME_W-1:0] now;
    int                r;
    req = ($urandom_range(0, 99) < 30) ? REQ_TICK : REQ_PLAY;
    fx  = FX_W'($urandom_range(0, 15));
    r   = $urandom_range(0, 99);
    if (r < 6) cnt = 4'd0;
    else if (r < 14) cnt = COUNT_W'($urandom_range(9, 15));
    else cnt = COUNT_W'($urandom_range(1, 8));
    r = $urandom_range(0, 99);
    if (r < 80) reload = CD_W'($urandom_range(0, 2));
    else if (r < 97) reload = CD_W'($urandom_range(3, 12));
    else begin
      reload = CD_W'($urandom_range(0, 65535));
      fx     = 4'd15;
    end
    busy = ($urandom_range(0, 99) < 45) ? 8'hFF : 8'($urandom_range(0, 255));
    now  = ($urandom_range(0, 99) < 30) ? 32'($urandom_range(0, 3)) : 32'($urandom());
    send_req(req, fx, cnt, reload, busy, now);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_cnt, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int stall;
    repeat (10) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(REQ_PLAY, 4'd0, 4'd1, 16'h0000, 8'h00, 32'h0000_0000);
    send_req(REQ_PLAY, 4'd0, 4'd8, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
    send_req(REQ_PLAY, 4'd0, 4'd8, 16'h0000, 8'hFF, 32'h0000_0005);
    send_req(REQ_PLAY, 4'd1, 4'd0, 16'h0003, 8'h00, 32'h0000_0007);
    send_req(REQ_PLAY, 4'd2, 4'd15, 16'h0000, 8'h7F, 32'h0000_0009);
    send_req(REQ_PLAY, 4'd3, 4'd3, 16'h0000, 8'hF8, 32'h0000_0001);
    send_req(REQ_PLAY, 4'd3, 4'd3, 16'h0002, 8'h07, 32'h0000_0002);
    send_req(REQ_PLAY, 4'd3, 4'd3, 16'h0000, 8'h00, 32'h0000_0004);
    send_req(REQ_TICK, 4'hF, 4'hF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    send_req(REQ_PLAY, 4'd3, 4'd3, 16'h0000, 8'h00, 32'h0000_0006);
    send_req(REQ_TICK, 4'h0, 4'h0, 16'h0000, 8'h00, 32'h0000_0000);
    send_req(REQ_PLAY, 4'd3, 4'd3, 16'h0000, 8'h07, 32'h0000_0003);
    send_req(REQ_PLAY, 4'd15, 4'd8, 16'hFFFF, 8'h7F, 32'hFFFF_FFFF);
    send_req(REQ_PLAY, 4'd15, 4'd8, 16'h0000, 8'hFF, 32'h0000_0001);
    send_req(REQ_PLAY, 4'd14, 4'd8, 16'h0100, 8'h00, 32'hAAAA_5555);
    send_req(REQ_PLAY, 4'd4, 4'd9, 16'h0081, 8'hFF, 32'h5555_AAAA);
    send_req(REQ_PLAY, 4'd5, 4'd8, 16'h0000, 8'h80, 32'h8000_0000);
    drain_results();

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 100 == 0) quiet = ($urandom_range(0, 4) == 0);
      send_random();
      if (k % 250 == 249) drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d play requests (%0d granted, %0d by stealing) and %0d ticks",
             plays_sent, grants, steals, ticks_sent);
    $display("checker counted %0d mismatches", fail_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
